// File: hw/rtl/bzr_pkg.sv
// Package for the buzzer alarm pattern sequencer: request/response types, codes and pattern table.
`timescale 1ns / 1ps
`default_nettype none

package bzr_pkg;

    localparam int unsigned DUTY_MAX = 1023;

    // duty = vol * DUTY_MAX / 100 done as vol * DUTY_RECIP >> DUTY_SHIFT (exact for vol <= 100)
    localparam int unsigned     DUTY_SHIFT    = 16;
    localparam longint unsigned DUTY_RECIP_L  = ((longint'(DUTY_MAX) << DUTY_SHIFT) + 99) / 100;
    localparam logic [31:0]     DUTY_RECIP    = 32'(DUTY_RECIP_L);

    localparam logic [6:0]  VOLUME_TOP   = 7'd100;
    localparam logic [14:0] FREQ_LOW     = 15'd100;
    localparam logic [14:0] FREQ_HIGH    = 15'd20000;
    localparam logic [14:0] FREQ_RESET   = 15'd2500;
    localparam logic [6:0]  LEVEL_MAX_RESET    = 7'd100;
    localparam logic [6:0]  LEVEL_HIGH_RESET   = 7'd80;
    localparam logic [6:0]  LEVEL_MEDIUM_RESET = 7'd50;

    typedef enum logic [1:0] {
        REG_LEVEL_MAX    = 2'd0,
        REG_LEVEL_HIGH   = 2'd1,
        REG_LEVEL_MEDIUM = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_MANUAL_ON = 3'd3,
        OP_SET_VOL   = 3'd4,
        OP_SET_FREQ  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FIRE    = 2'd0,
        KIND_WARNING = 2'd1,
        KIND_SUCCESS = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  alarm_kind;
        logic [15:0] limit_ms;
        logic [7:0]  volume_req;
        logic [15:0] freq_req;
    } req_t;

    typedef struct packed {
        logic [9:0]  duty;
        logic [14:0] tone_hz;
        logic        sounding;
        logic        alarm_busy;
        logic        alarm_done;
        logic        status;
    } rsp_t;

    typedef struct packed {
        logic [14:0] tone;
        reg_idx_t    level_idx;
        logic [8:0]  on_ms;
        logic [8:0]  off_ms;
        logic [2:0]  count;     // 0 = endless
    } pattern_t;

    function automatic pattern_t pattern_of(input logic [1:0] sel);
        pattern_t p;
        unique case (kind_t'(sel))
            KIND_FIRE:    p = '{15'd3000, REG_LEVEL_MAX,    9'd200, 9'd150, 3'd0};
            KIND_WARNING: p = '{15'd2000, REG_LEVEL_HIGH,   9'd300, 9'd300, 3'd5};
            KIND_SUCCESS: p = '{15'd2500, REG_LEVEL_MEDIUM, 9'd150, 9'd100, 3'd2};
            KIND_ERROR:   p = '{15'd800,  REG_LEVEL_HIGH,   9'd500, 9'd200, 3'd3};
            default:      p = '{15'd3000, REG_LEVEL_MAX,    9'd200, 9'd150, 3'd0};
        endcase
        return p;
    endfunction

    function automatic logic [6:0] clamp_volume(input logic [7:0] v);
        return (v > 8'(VOLUME_TOP)) ? VOLUME_TOP : v[6:0];
    endfunction

    function automatic logic [14:0] clamp_freq(input logic [15:0] f);
        logic [14:0] r;
        if (f < 16'(FREQ_LOW)) begin
            r = FREQ_LOW;
        end else if (f > 16'(FREQ_HIGH)) begin
            r = FREQ_HIGH;
        end else begin
            r = f[14:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/buzzer_alarm_pattern_sequencer.sv
// Buzzer alarm pattern sequencer: plays alarm patterns from 1 ms tick requests.
//
// Takes one request per clock while responses are taken (tick, start alarm, stop,
// manual on, set volume, set frequency) and returns exactly one response for
// each, in the cycle after acceptance, from a response register; a new request
// is taken in the same cycle a waiting response is taken, so the sustained rate
// is one request per clock. All pattern state updates and the duty product for
// a request are combinational, between the state and response registers.
// The user writes the three level registers (cfg_wr_en/cfg_index/cfg_data) only
// while no request is in flight; the block does not enforce it. Index 3 writes are ignored.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_alarm_pattern_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [6:0]    cfg_data,
    input  logic          req_valid,
    output logic          req_ready,
    input  bzr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bzr_pkg::rsp_t rsp
);
    import bzr_pkg::*;

    localparam int PROD_W = 7 + 32;

    logic [6:0]  level_max_reg, level_high_reg, level_medium_reg;

    phase_t      phase_reg, phase_next;
    logic [8:0]  phase_ms_reg, phase_ms_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [2:0]  repeats_reg, repeats_next;
    logic [1:0]  sel_reg, sel_next;
    logic [15:0] limit_reg, limit_next;
    logic [6:0]  volume_reg, volume_next;
    logic [14:0] freq_reg, freq_next;
    logic        output_on_reg, output_on_next;

    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;

    logic        req_fire;
    pattern_t    cur_pat, new_pat;
    logic [8:0]  ms_inc;
    logic [17:0] elapsed_sum;
    logic [16:0] elapsed_add;
    logic [2:0]  repeats_inc;
    logic        limit_hit;
    logic        done, bad;
    logic [6:0]  new_level;
    logic [PROD_W-1:0] duty_prod;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cur_pat = pattern_of(sel_reg);
    assign new_pat = pattern_of(req.alarm_kind[1:0]);
    assign ms_inc  = phase_ms_reg + 9'd1;

    always_comb
    begin
        unique case (new_pat.level_idx)
            REG_LEVEL_MAX:    new_level = clamp_volume({1'b0, level_max_reg});
            REG_LEVEL_HIGH:   new_level = clamp_volume({1'b0, level_high_reg});
            REG_LEVEL_MEDIUM: new_level = clamp_volume({1'b0, level_medium_reg});
            default:          new_level = clamp_volume({1'b0, level_max_reg});
        endcase
    end

    // phase end time added to elapsed, saturating
    always_comb
    begin
        elapsed_sum = {1'b0, elapsed_reg}
                    + 18'((phase_reg == PH_ON) ? cur_pat.on_ms : cur_pat.off_ms);
        elapsed_add = elapsed_sum[17] ? '1 : elapsed_sum[16:0];
        limit_hit   = (limit_reg != 16'd0) && (elapsed_add >= {1'b0, limit_reg});
        repeats_inc = repeats_reg + 3'd1;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        phase_ms_next  = phase_ms_reg;
        elapsed_next   = elapsed_reg;
        repeats_next   = repeats_reg;
        sel_next       = sel_reg;
        limit_next     = limit_reg;
        volume_next    = volume_reg;
        freq_next      = freq_reg;
        output_on_next = output_on_reg;
        done           = 1'b0;
        bad            = 1'b0;

        unique case (req.op)
            OP_TICK:
            begin
                if (phase_reg == PH_ON) begin
                    if (ms_inc < cur_pat.on_ms) begin
                        phase_ms_next = ms_inc;
                    end else begin
                        elapsed_next  = elapsed_add;
                        phase_ms_next = '0;
                        if (limit_hit) begin
                            done = 1'b1;
                        end else begin
                            output_on_next = 1'b0;
                            phase_next     = PH_OFF;
                        end
                    end
                end else if (phase_reg == PH_OFF) begin
                    if (ms_inc < cur_pat.off_ms) begin
                        phase_ms_next = ms_inc;
                    end else begin
                        elapsed_next  = elapsed_add;
                        phase_ms_next = '0;
                        if (limit_hit) begin
                            done = 1'b1;
                        end else if (cur_pat.count != 3'd0) begin
                            repeats_next = repeats_inc;
                            if (repeats_inc >= cur_pat.count) begin
                                done = 1'b1;
                            end else begin
                                output_on_next = 1'b1;
                                phase_next     = PH_ON;
                            end
                        end else begin
                            output_on_next = 1'b1;
                            phase_next     = PH_ON;
                        end
                    end
                end
                if (done) begin
                    output_on_next = 1'b0;
                    phase_next     = PH_IDLE;
                    phase_ms_next  = '0;
                end
            end
            OP_START:
            begin
                if (req.alarm_kind[2]) begin
                    bad = 1'b1;
                end else begin
                    volume_next    = new_level;
                    freq_next      = clamp_freq(16'(new_pat.tone));
                    output_on_next = 1'b1;
                    phase_next     = PH_ON;
                    phase_ms_next  = '0;
                    elapsed_next   = '0;
                    repeats_next   = '0;
                    sel_next       = req.alarm_kind[1:0];
                    limit_next     = req.limit_ms;
                end
            end
            OP_STOP:
            begin
                output_on_next = 1'b0;
                phase_next     = PH_IDLE;
                phase_ms_next  = '0;
            end
            OP_MANUAL_ON:
            begin
                output_on_next = 1'b1;
                phase_next     = PH_IDLE;
                phase_ms_next  = '0;
            end
            OP_SET_VOL:
            begin
                volume_next = clamp_volume(req.volume_req);
            end
            OP_SET_FREQ:
            begin
                freq_next = clamp_freq(req.freq_req);
            end
            default:
            begin
            end
        endcase
    end

    assign duty_prod = PROD_W'(volume_next) * PROD_W'(DUTY_RECIP);

    always_comb
    begin
        rsp_next.duty       = output_on_next ? duty_prod[DUTY_SHIFT +: 10] : 10'd0;
        rsp_next.tone_hz    = freq_next;
        rsp_next.sounding   = output_on_next;
        rsp_next.alarm_busy = (phase_next == PH_ON) || (phase_next == PH_OFF);
        rsp_next.alarm_done = done;
        rsp_next.status     = bad;
    end

    always_comb
    begin
        if (req_fire) begin
            rsp_valid_next = 1'b1;
        end else if (rsp_ready) begin
            rsp_valid_next = 1'b0;
        end else begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            level_max_reg    <= LEVEL_MAX_RESET;
            level_high_reg   <= LEVEL_HIGH_RESET;
            level_medium_reg <= LEVEL_MEDIUM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEVEL_MAX:    level_max_reg    <= cfg_data;
                REG_LEVEL_HIGH:   level_high_reg   <= cfg_data;
                REG_LEVEL_MEDIUM: level_medium_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            phase_ms_reg  <= '0;
            elapsed_reg   <= '0;
            repeats_reg   <= '0;
            sel_reg       <= '0;
            limit_reg     <= '0;
            volume_reg    <= '0;
            freq_reg      <= FREQ_RESET;
            output_on_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            rsp_valid_reg <= rsp_valid_next;
            if (req_fire) begin
                phase_reg     <= phase_next;
                phase_ms_reg  <= phase_ms_next;
                elapsed_reg   <= elapsed_next;
                repeats_reg   <= repeats_next;
                sel_reg       <= sel_next;
                limit_reg     <= limit_next;
                volume_reg    <= volume_next;
                freq_reg      <= freq_next;
                output_on_reg <= output_on_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire) begin
            rsp_reg <= rsp_next;
        end
    end

    // on phase always drives the buzzer
    a_on_phase_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ON) |-> output_on_reg)
        else $error("on phase with output off");

    // phase timer stays inside the current phase length
    a_phase_ms_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_ON) |-> (phase_ms_reg < cur_pat.on_ms)) and
        ((phase_reg == PH_OFF) |-> (phase_ms_reg < cur_pat.off_ms)))
        else $error("phase timer out of range");

    // a silent response carries zero duty
    a_silent_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.sounding) |-> (rsp_reg.duty == 10'd0))
        else $error("duty while silent");

    // finish and invalid kind never come from the same request
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.alarm_done && rsp_reg.status))
        else $error("done and error on one response");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the buzzer alarm pattern sequencer: directed table, random alarm runs.
`timescale 1ns / 1ps

module tb_top;
    import bzr_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RAND_PER_PHASE = 375;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT        = 300;

    localparam logic [2:0] OP_SPARE_6     = 3'd6;
    localparam logic [2:0] OP_SPARE_7     = 3'd7;
    localparam logic [2:0] KIND_INVALID_4 = 3'd4;
    localparam logic [2:0] KIND_INVALID_7 = 3'd7;

    typedef struct packed {
        logic [14:0] tone;
        reg_idx_t    lvl;
        logic [8:0]  on_ms;
        logic [8:0]  off_ms;
        logic [2:0]  reps;
    } alarm_shape_t;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [6:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    rsp_t rsp_due [$];
    int sent_cnt, done_cnt, bad_cnt, typed_cnt, cfg_cnt, errors, cycles;
    bit calm;

    // predictor state
    logic [6:0]  level_pct [3];
    phase_t      ph;
    logic [8:0]  ph_ms;
    logic [16:0] run_ms;
    logic [2:0]  reps;
    logic [1:0]  sel;
    logic [15:0] limit_q;
    logic [6:0]  vol;
    logic [14:0] tone;
    logic        spk_on;

    buzzer_alarm_pattern_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // level_max starts at 127 here, so the fire start checks the clamp to 100
    dir_row_t dir_rows [25] = '{
        '{'{OP_TICK, '0, '0, '0, '0}, 1'b1,
          '{10'd0, 15'd2500, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_SET_FREQ, KIND_INVALID_7, 16'hFFFF, 8'hFF, 16'h0000}, 1'b1,
          '{10'd0, 15'd100, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_SET_FREQ, '0, '0, '0, 16'hFFFF}, 1'b1,
          '{10'd0, 15'd20000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_SET_FREQ, '0, '0, '0, 16'd99}, 1'b0, '0},
        '{'{OP_SET_FREQ, '0, '0, '0, 16'd20001}, 1'b0, '0},
        '{'{OP_SET_VOL, '0, '0, 8'hFF, '0}, 1'b1,
          '{10'd0, 15'd20000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_MANUAL_ON, '0, '0, '0, '0}, 1'b1,
          '{10'd1023, 15'd20000, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{OP_SET_VOL, '0, '0, 8'd0, '0}, 1'b1,
          '{10'd0, 15'd20000, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{OP_SET_VOL, '0, '0, 8'd101, '0}, 1'b1,
          '{10'd1023, 15'd20000, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{OP_SET_VOL, '0, '0, 8'd50, '0}, 1'b0, '0},
        '{'{OP_STOP, '0, '0, '0, '0}, 1'b1,
          '{10'd0, 15'd20000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_START, KIND_INVALID_7, 16'd10, '0, '0}, 1'b1,
          '{10'd0, 15'd20000, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{OP_START, 3'(KIND_FIRE), 16'd0, '0, '0}, 1'b1,
          '{10'd1023, 15'd3000, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{'{OP_START, KIND_INVALID_4, '0, '0, '0}, 1'b1,
          '{10'd1023, 15'd3000, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{'{OP_SPARE_6, '0, '0, '0, '0}, 1'b0, '0},
        '{'{OP_SPARE_7, '1, '1, '1, '1}, 1'b0, '0},
        '{'{OP_TICK, '0, '0, '0, '0}, 1'b0, '0},
        '{'{OP_SET_FREQ, '0, '0, '0, 16'd12345}, 1'b0, '0},
        '{'{OP_SET_VOL, '0, '0, 8'd33, '0}, 1'b0, '0},
        '{'{OP_START, 3'(KIND_SUCCESS), 16'hFFFF, '0, '0}, 1'b0, '0},
        '{'{OP_TICK, '0, '0, '0, '0}, 1'b0, '0},
        '{'{OP_MANUAL_ON, '0, '0, '0, '0}, 1'b0, '0},
        '{'{OP_START, 3'(KIND_ERROR), 16'd1, '0, '0}, 1'b0, '0},
        '{'{OP_STOP, '0, '0, '0, '0}, 1'b0, '0},
        '{'{OP_START, 3'(KIND_WARNING), 16'd0, '0, '0}, 1'b0, '0}
    };

    function automatic alarm_shape_t shape_of(input logic [1:0] k);
        alarm_shape_t s;
        case (kind_t'(k))
            KIND_WARNING: s = '{15'd2000, REG_LEVEL_HIGH,   9'd300, 9'd300, 3'd5};
            KIND_SUCCESS: s = '{15'd2500, REG_LEVEL_MEDIUM, 9'd150, 9'd100, 3'd2};
            KIND_ERROR:   s = '{15'd800,  REG_LEVEL_HIGH,   9'd500, 9'd200, 3'd3};
            default:      s = '{15'd3000, REG_LEVEL_MAX,    9'd200, 9'd150, 3'd0};
        endcase
        return s;
    endfunction

    // adds a finished phase to the run time, saturating; true once the limit is hit
    function automatic bit run_add_hits(input logic [8:0] ms);
        logic [17:0] sum;
        sum = 18'(run_ms) + 18'(ms);
        run_ms = sum[17] ? '1 : sum[16:0];
        return limit_q != '0 && 17'(limit_q) <= run_ms;
    endfunction

    // one ms of pattern play; true when the alarm runs out
    function automatic bit tick_alarm();
        alarm_shape_t s;
        s = shape_of(sel);
        if (ph != PH_ON && ph != PH_OFF) return 1'b0;
        ph_ms = ph_ms + 9'd1;
        if (ph == PH_ON)
        begin
            if (ph_ms < s.on_ms) return 1'b0;
            ph_ms = '0;
            if (run_add_hits(s.on_ms)) return 1'b1;
            spk_on = 1'b0;
            ph = PH_OFF;
            return 1'b0;
        end
        if (ph_ms < s.off_ms) return 1'b0;
        ph_ms = '0;
        if (run_add_hits(s.off_ms)) return 1'b1;
        if (s.reps != '0)
        begin
            reps = reps + 3'd1;
            if (reps >= s.reps) return 1'b1;
        end
        spk_on = 1'b1;
        ph = PH_ON;
        return 1'b0;
    endfunction

    function automatic rsp_t buzzer_next(input req_t r);
        rsp_t o;
        alarm_shape_t s;
        bit fin;
        bit bad;
        int unsigned duty;
        fin = 1'b0;
        bad = 1'b0;
        case (r.op)
            OP_TICK:
            begin
                if (tick_alarm())
                begin
                    fin = 1'b1;
                    spk_on = 1'b0;
                    ph = PH_IDLE;
                    ph_ms = '0;
                end
            end
            OP_START:
            begin
                if (r.alarm_kind > 3'(KIND_ERROR))
                begin
                    bad = 1'b1;
                end
                else
                begin
                    s = shape_of(r.alarm_kind[1:0]);
                    vol = (level_pct[s.lvl] > VOLUME_TOP) ? VOLUME_TOP : level_pct[s.lvl];
                    tone = s.tone;
                    spk_on = 1'b1;
                    ph = PH_ON;
                    ph_ms = '0;
                    run_ms = '0;
                    reps = '0;
                    sel = r.alarm_kind[1:0];
                    limit_q = r.limit_ms;
                end
            end
            OP_STOP:
            begin
                spk_on = 1'b0;
                ph = PH_IDLE;
                ph_ms = '0;
            end
            OP_MANUAL_ON:
            begin
                spk_on = 1'b1;
                ph = PH_IDLE;
                ph_ms = '0;
            end
            OP_SET_VOL:
            begin
                vol = (r.volume_req > 8'(VOLUME_TOP)) ? VOLUME_TOP : r.volume_req[6:0];
            end
            OP_SET_FREQ:
            begin
                if (r.freq_req < 16'(FREQ_LOW))
                    tone = FREQ_LOW;
                else if (r.freq_req > 16'(FREQ_HIGH))
                    tone = FREQ_HIGH;
                else
                    tone = r.freq_req[14:0];
            end
            default: ;
        endcase
        duty = spk_on ? (int'(vol) * DUTY_MAX) / 100 : 0;
        o.duty = 10'(duty);
        o.tone_hz = tone;
        o.sounding = spk_on;
        o.alarm_busy = (ph == PH_ON || ph == PH_OFF);
        o.alarm_done = fin;
        o.status = bad;
        return o;
    endfunction

    function automatic req_t random_fields();
        req_t r;
        r.op = 3'($urandom_range(0, 7));
        r.alarm_kind = 3'($urandom_range(0, 7));
        r.limit_ms = 16'($urandom);
        r.volume_req = 8'($urandom);
        r.freq_req = 16'($urandom);
        return r;
    endfunction

    // mostly harmless commands that can land in the middle of an alarm
    function automatic req_t noise_req();
        req_t r;
        r = random_fields();
        case ($urandom_range(0, 9))
            0, 1, 2: r.op = OP_SET_VOL;
            3, 4:    r.op = OP_SET_FREQ;
            5:
            begin
                r.op = OP_START;
                r.alarm_kind = 3'($urandom_range(KIND_INVALID_4, KIND_INVALID_7));
            end
            6:       r.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            7:       r.op = OP_STOP;
            8:       r.op = OP_MANUAL_ON;
            default: ;
        endcase
        return r;
    endfunction

    // called at a clock edge; returns at the edge where the request is taken
    task automatic send_request(input req_t r, input bit typed = 1'b0, input rsp_t want = '0);
        rsp_t model;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        model = buzzer_next(r);
        sent_cnt++;
        if (model.alarm_done) done_cnt++;
        if (model.status) bad_cnt++;
        if (typed) typed_cnt++;
        rsp_due.push_back(typed ? want : model);
    endtask

    task automatic load_levels(input logic [6:0] lmax, input logic [6:0] lhigh,
                               input logic [6:0] lmed, input logic [6:0] spare);
        logic [6:0] v [4];
        v = '{lmax, lhigh, lmed, spare};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= v[i];
            @(posedge clk);
            if (i <= int'(REG_LEVEL_MEDIUM)) level_pct[i] = v[i];
            cfg_cnt++;
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // a random start, then a run of ticks with rare noise cut short at the goal, then stray requests
    task automatic alarm_burst(input int goal);
        req_t r;
        int n_ticks;
        r = random_fields();
        r.op = OP_START;
        r.alarm_kind = 3'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1:    r.limit_ms = '0;
            2:       ;
            3, 4:    r.limit_ms = 16'($urandom_range(201, 2000));
            default: r.limit_ms = 16'($urandom_range(1, 200));
        endcase
        send_request(r);
        n_ticks = $urandom_range(50, 1200);
        while (n_ticks > 0 && sent_cnt < goal)
        begin
            r = random_fields();
            if ($urandom_range(0, 39) == 0)
                r = noise_req();
            else
                r.op = OP_TICK;
            send_request(r);
            n_ticks--;
        end
        repeat ($urandom_range(0, 6))
        begin
            send_request($urandom_range(0, 1) ? noise_req() : random_fields());
        end
    endtask

    initial
    begin : stimulus
        int ph_i;
        int goal;
        level_pct = '{LEVEL_MAX_RESET, LEVEL_HIGH_RESET, LEVEL_MEDIUM_RESET};
        ph = PH_IDLE;
        ph_ms = '0;
        run_ms = '0;
        reps = '0;
        sel = '0;
        limit_q = '0;
        vol = '0;
        tone = FREQ_RESET;
        spk_on = 1'b0;
        calm = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_levels(7'd127, LEVEL_HIGH_RESET, LEVEL_MEDIUM_RESET, 7'h55);

        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
        end

        for (ph_i = 0; ph_i < 4; ph_i++)
        begin
            wait_idle();
            case (ph_i)
                0:       load_levels(7'd0, 7'd100, 7'd127, 7'h2A);
                1:       load_levels(7'd127, 7'd0, 7'd101, 7'h7F);
                2:       load_levels(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
                default: load_levels(LEVEL_MAX_RESET, LEVEL_HIGH_RESET, LEVEL_MEDIUM_RESET, '0);
            endcase
            calm = (ph_i == 3);
            goal = sent_cnt + RAND_PER_PHASE;
            while (sent_cnt < goal)
            begin
                alarm_burst(goal);
            end
        end

        wait_idle();
        repeat (5) @(posedge clk);
        $display("summary: %0d requests (%0d from the table), %0d alarms ran out, %0d bad kinds",
                 sent_cnt, typed_cnt, done_cnt, bad_cnt);
        $display("summary: %0d level writes over 5 settings, one long response hold-off", cfg_cnt);
        if (errors == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // response side: random stalls, one long hold-off so the request side backs up
    initial
    begin : rsp_sink
        int n;
        bit held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!held && sent_cnt >= HOLD_AT)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                n = HOLD_CYCLES;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                rsp_ready <= 1'b0;
                n = $urandom_range(1, 11);
            end
            else
            begin
                rsp_ready <= 1'b1;
                n = $urandom_range(1, 30);
            end
            repeat (n) @(posedge clk);
        end
    end

    task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
        if (exp != act)
        begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("response with nothing expected: %h", rsp);
                errors++;
            end
            else
            begin
                want = rsp_due.pop_front();
                check_field("duty", 32'(want.duty), 32'(rsp.duty));
                check_field("tone_hz", 32'(want.tone_hz), 32'(rsp.tone_hz));
                check_field("sounding", 32'(want.sounding), 32'(rsp.sounding));
                check_field("alarm_busy", 32'(want.alarm_busy), 32'(rsp.alarm_busy));
                check_field("alarm_done", 32'(want.alarm_done), 32'(rsp.alarm_done));
                check_field("status", 32'(want.status), 32'(rsp.status));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles, rsp_due.size());
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule
